FILE: rtl/core/rcpp_pkg.sv
package rcpp_pkg;

   // request codes
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_RING   = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CODING = 2'd0;
   localparam logic [1:0] KIND_PAIR   = 2'd1;
   localparam logic [1:0] KIND_NONE   = 2'd2;

   // core link table codes (values below 256 are ring indexes)
   localparam logic [8:0] LINK_FREE    = 9'd256;
   localparam logic [8:0] LINK_INVALID = 9'd257;

   // ring link codes (values below 64 are core indexes)
   localparam logic [6:0] RLINK_FREE    = 7'd64;
   localparam logic [6:0] RLINK_INVALID = 7'd65;

   // distance test: 80 sixteenths is 5 px, 6400 is its square
   localparam logic [15:0] NEAR_LIMIT = 16'd80;
   localparam logic [13:0] D2_LIMIT   = 14'd6400;

   // shared multiplier
   localparam int MUL_W  = 11;
   localparam int PROD_W = 2 * MUL_W;

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

endpackage

FILE: rtl/core/rcpp_ram.sv
module rcpp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/rcpp_mul.sv
module rcpp_mul
   import rcpp_pkg::*;
(
   input  logic              clock,
   input  mul_req_type       mul_req,
   output logic [PROD_W-1:0] product
);
   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

FILE: rtl/core/ring_core_pairing_prune_top.sv
// Channel  Dir  Ports                                           Handshake
// req      in   req_type req_pos_col req_pos_row req_ring_width  req_valid/req_ready
//               req_ring_height req_is_coding
// rsp      out  rsp_result_kind rsp_ring_index rsp_core_index    rsp_valid/rsp_ready
//               rsp_overflow rsp_last
//
// Core load: ST_IDLE. Coding ring: ST_CODE. Other ring, per core: ST_RRD, ST_RDX,
// ST_RSQX, ST_RSQY, ST_RDEC, using the shared multiplier and table read. Finish:
// ST_FRD, ST_FCHK per core, then ST_FEND. Coding ring and finish wait on rsp_ready.
// Synchronous active-high reset clears counts, flag and state; tables need no clear.
// req_ready is high only when the sequencer is idle; one rsp item is held in an
// output register, so a new item is accepted while it waits.
module ring_core_pairing_prune_top
   import rcpp_pkg::*;
#(
   parameter int MAX_CORES = 64,
   parameter int MAX_RINGS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_pos_col,
   input  logic [15:0] req_pos_row,
   input  logic [9:0]  req_ring_width,
   input  logic [9:0]  req_ring_height,
   input  logic        req_is_coding,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_ring_index,
   output logic [5:0]  rsp_core_index,
   output logic        rsp_overflow,
   output logic        rsp_last
);
   localparam int CIW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int CCW = $clog2(MAX_CORES + 1);
   localparam int RCW = $clog2(MAX_RINGS + 1);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_CODE = 10'b0000000010,
      ST_RRD  = 10'b0000000100,
      ST_RDX  = 10'b0000001000,
      ST_RSQX = 10'b0000010000,
      ST_RSQY = 10'b0000100000,
      ST_RDEC = 10'b0001000000,
      ST_FRD  = 10'b0010000000,
      ST_FCHK = 10'b0100000000,
      ST_FEND = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CCW-1:0] core_count_ff, core_count_in;
   logic [RCW-1:0] ring_count_ff, ring_count_in;
   logic           dropped_ff, dropped_in;
   logic [CCW-1:0] idx_ff, idx_in;
   logic [6:0]     link_ff, link_in;
   logic           connected_ff, connected_in;
   logic           have_pend_ff, have_pend_in;

   logic [15:0]    col_ff, row_ff;
   logic [10:0]    s_ff;
   logic [7:0]     ring_idx_ff;
   logic [PROD_W-1:0] s2_ff;
   logic [6:0]     dx_ff, dy_ff;
   logic           far_ff;
   logic [12:0]    acc_ff;
   logic [7:0]     pend_ring_ff;
   logic [5:0]     pend_core_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     kind_ff, kind_in;
   logic [7:0]     oring_ff, oring_in;
   logic [5:0]     ocore_ff, ocore_in;
   logic           oflow_ff;
   logic           olast_ff, olast_in;
   logic           emit;

   logic           accept;
   logic           out_free;
   logic [CIW-1:0] rd_addr;
   logic [31:0]    pos_rd;
   logic [8:0]     link_rd;
   logic           pos_we;
   logic           link_we;
   logic [CIW-1:0] link_waddr;
   logic [8:0]     link_wdata;
   mul_req_type    mul_req;
   logic [PROD_W-1:0] product;

   logic [15:0]    ccol, crow, dx, dy;
   logic [13:0]    d2;
   logic [29:0]    lhs, rhs;
   logic           hit;
   logic           idx_last;
   logic [8:0]     ring_count_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rd_addr   = idx_ff[CIW-1:0];
   assign idx_last  = ((idx_ff + 1'b1) == core_count_ff);
   assign ring_count_ext = 9'(ring_count_ff);

   rcpp_ram #(.WIDTH(32), .DEPTH(MAX_CORES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (core_count_ff[CIW-1:0]),
      .wr_data ({req_pos_row, req_pos_col}),
      .rd_addr (rd_addr),
      .rd_data (pos_rd)
   );

   rcpp_ram #(.WIDTH(9), .DEPTH(MAX_CORES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   rcpp_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   // distance datapath
   assign ccol = pos_rd[15:0];
   assign crow = pos_rd[31:16];
   assign dx   = (ccol > col_ff) ? (ccol - col_ff) : (col_ff - ccol);
   assign dy   = (crow > row_ff) ? (crow - row_ff) : (row_ff - crow);
   assign d2   = 14'(acc_ff) + 14'(product[12:0]);
   assign lhs  = (30'(d2) << 4) + (30'(d2) << 3) + 30'(d2);
   assign rhs  = (30'(s2_ff) << 7) + (30'(s2_ff) << 4);
   assign hit  = ~far_ff && (d2 < D2_LIMIT) && (lhs < rhs);

   always_comb begin
      case (state_ff)
         ST_RSQX: mul_req = '{a: 11'(dx_ff), b: 11'(dx_ff)};
         ST_RSQY: mul_req = '{a: 11'(dy_ff), b: 11'(dy_ff)};
         default: mul_req = '{a: s_ff, b: s_ff};
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      core_count_in = core_count_ff;
      ring_count_in = ring_count_ff;
      dropped_in    = dropped_ff;
      idx_in        = idx_ff;
      link_in       = link_ff;
      connected_in  = connected_ff;
      have_pend_in  = have_pend_ff;
      pos_we        = 1'b0;
      link_we       = 1'b0;
      link_waddr    = core_count_ff[CIW-1:0];
      link_wdata    = LINK_FREE;
      emit          = 1'b0;
      kind_in       = KIND_CODING;
      oring_in      = ring_idx_ff;
      ocore_in      = '0;
      olast_in      = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_LOAD: begin
                     if (core_count_ff < CCW'(MAX_CORES)) begin
                        pos_we        = 1'b1;
                        link_we       = 1'b1;
                        core_count_in = core_count_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  REQ_RING: begin
                     if (32'(ring_count_ff) >= MAX_RINGS) begin
                        dropped_in = 1'b1;
                     end else begin
                        ring_count_in = ring_count_ff + 1'b1;
                        idx_in        = '0;
                        link_in       = RLINK_FREE;
                        connected_in  = 1'b0;
                        if (req_is_coding) begin
                           state_in = ST_CODE;
                        end else if (core_count_ff != '0) begin
                           state_in = ST_RRD;
                        end
                     end
                  end
                  REQ_FINISH: begin
                     idx_in       = '0;
                     have_pend_in = 1'b0;
                     state_in     = (core_count_ff != '0) ? ST_FRD : ST_FEND;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CODE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RRD:  state_in = ST_RDX;
         ST_RDX:  state_in = ST_RSQX;
         ST_RSQX: state_in = ST_RSQY;
         ST_RSQY: state_in = ST_RDEC;
         ST_RDEC: begin
            if (hit) begin
               if (connected_ff) begin
                  if (link_ff < RLINK_FREE) begin
                     link_we    = 1'b1;
                     link_waddr = link_ff[CIW-1:0];
                     link_wdata = LINK_FREE;
                  end
                  link_in = RLINK_INVALID;
               end else begin
                  connected_in = 1'b1;
                  link_waddr   = rd_addr;
                  if (link_rd == LINK_FREE) begin
                     link_we    = 1'b1;
                     link_wdata = {1'b0, ring_idx_ff};
                     link_in    = 7'(idx_ff);
                  end else if (link_rd == LINK_INVALID) begin
                     link_in = RLINK_INVALID;
                  end else begin
                     link_we    = 1'b1;
                     link_wdata = LINK_INVALID;
                     link_in    = RLINK_INVALID;
                  end
               end
            end
            idx_in   = idx_ff + 1'b1;
            state_in = idx_last ? ST_IDLE : ST_RRD;
         end
         ST_FRD: state_in = ST_FCHK;
         ST_FCHK: begin
            if (!link_rd[8] && have_pend_ff && !out_free) begin
               state_in = ST_FCHK;
            end else begin
               if (!link_rd[8]) begin
                  if (have_pend_ff) begin
                     emit     = 1'b1;
                     kind_in  = KIND_PAIR;
                     oring_in = pend_ring_ff;
                     ocore_in = pend_core_ff;
                     olast_in = 1'b0;
                  end
                  have_pend_in = 1'b1;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = idx_last ? ST_FEND : ST_FRD;
            end
         end
         ST_FEND: begin
            if (out_free) begin
               emit = 1'b1;
               if (have_pend_ff) begin
                  kind_in  = KIND_PAIR;
                  oring_in = pend_ring_ff;
                  ocore_in = pend_core_ff;
               end else begin
                  kind_in  = KIND_NONE;
                  oring_in = '0;
               end
               core_count_in = '0;
               ring_count_in = '0;
               dropped_in    = 1'b0;
               link_in       = RLINK_FREE;
               have_pend_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         core_count_ff <= '0;
         ring_count_ff <= '0;
         dropped_ff    <= 1'b0;
         idx_ff        <= '0;
         link_ff       <= RLINK_FREE;
         connected_ff  <= 1'b0;
         have_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         core_count_ff <= core_count_in;
         ring_count_ff <= ring_count_in;
         dropped_ff    <= dropped_in;
         idx_ff        <= idx_in;
         link_ff       <= link_in;
         connected_ff  <= connected_in;
         have_pend_ff  <= have_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff      <= req_pos_col;
         row_ff      <= req_pos_row;
         s_ff        <= 11'(req_ring_width) + 11'(req_ring_height);
         ring_idx_ff <= ring_count_ext[7:0];
      end
      if (state_ff == ST_RDX) begin
         s2_ff  <= product;
         dx_ff  <= dx[6:0];
         dy_ff  <= dy[6:0];
         far_ff <= (dx >= NEAR_LIMIT) || (dy >= NEAR_LIMIT);
      end
      if (state_ff == ST_RSQY) begin
         acc_ff <= product[12:0];
      end
      if (state_ff == ST_FCHK && !link_rd[8] && !(have_pend_ff && !out_free)) begin
         pend_ring_ff <= link_rd[7:0];
         pend_core_ff <= 6'(idx_ff);
      end
      if (emit) begin
         kind_ff  <= kind_in;
         oring_ff <= oring_in;
         ocore_ff <= ocore_in;
         oflow_ff <= dropped_ff;
         olast_ff <= olast_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_ring_index  = oring_ff;
   assign rsp_core_index  = ocore_ff;
   assign rsp_overflow    = oflow_ff;
   assign rsp_last        = olast_ff;
endmodule

FILE: dv/ring_core_pairing_prune_top_tb.sv
`timescale 1ns / 100ps

module ring_core_pairing_prune_top_tb;
   import rcpp_pkg::*;

   localparam int CORES        = 64;
   localparam int RINGS        = 256;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] col;
      logic [15:0] row;
      logic [9:0]  width;
      logic [9:0]  height;
      logic        coding;
   } blob_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ring;
      logic [5:0] core;
      logic       overflow;
      logic       last;
   } pair_rsp_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [15:0] req_pos_col;
   logic [15:0] req_pos_row;
   logic [9:0]  req_ring_width;
   logic [9:0]  req_ring_height;
   logic        req_is_coding;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_ring_index;
   logic [5:0]  rsp_core_index;
   logic        rsp_overflow;
   logic        rsp_last;

   ring_core_pairing_prune_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_pos_col     (req_pos_col),
      .req_pos_row     (req_pos_row),
      .req_ring_width  (req_ring_width),
      .req_ring_height (req_ring_height),
      .req_is_coding   (req_is_coding),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_ring_index  (rsp_ring_index),
      .rsp_core_index  (rsp_core_index),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   blob_item_type pending_items[$];
   pair_rsp_type  owed_results[$];
   blob_item_type next_item;
   pair_rsp_type  seen_rsp;
   pair_rsp_type  want_rsp;
   int         queued;
   int         errors;
   int         quiet_cycles;
   int         send_idle;
   int         recv_idle;
   bit         item_taken;

   // pairing state mirror
   logic [15:0] core_col  [CORES];
   logic [15:0] core_row  [CORES];
   logic [8:0]  core_link [CORES];
   int          n_cores;
   int          n_rings;
   logic        dropped;

   function automatic bit near_core(input int i, input logic [15:0] col,
                                    input logic [15:0] row, input logic [10:0] s);
      longint unsigned dx, dy, d2, s2;
      dx = (core_col[i] > col) ? core_col[i] - col : col - core_col[i];
      dy = (core_row[i] > row) ? core_row[i] - row : row - core_row[i];
      d2 = dx * dx + dy * dy;
      s2 = longint'(s) * longint'(s);
      return (d2 < D2_LIMIT) && (25 * d2 < 144 * s2);
   endfunction

   task automatic clear_tables();
      int i;
      for (i = 0; i < CORES; i++) core_link[i] = LINK_FREE;
      n_cores   = 0;
      n_rings   = 0;
      dropped   = 1'b0;
   endtask

   task automatic pair_step(input blob_item_type it);
      int         i, idx, last_i;
      bit         hit;
      logic [6:0] link;
      case (it.kind)
         REQ_LOAD: begin
            if (n_cores < CORES) begin
               core_col[n_cores]  = it.col;
               core_row[n_cores]  = it.row;
               core_link[n_cores] = LINK_FREE;
               n_cores++;
            end else begin
               dropped = 1'b1;
            end
         end
         REQ_RING: begin
            if (n_rings >= RINGS) begin
               dropped = 1'b1;
            end else begin
               idx = n_rings;
               n_rings++;
               if (it.coding) begin
                  owed_results.insert(owed_results.size(),
                                      {KIND_CODING, idx[7:0], 6'd0, dropped, 1'b1});
               end else begin
                  link = RLINK_FREE;
                  hit  = 1'b0;
                  for (i = 0; i < n_cores; i++) begin
                     if (near_core(i, it.col, it.row,
                                   {1'b0, it.width} + {1'b0, it.height})) begin
                        if (hit) begin
                           // ring touches a second core: release its first claim
                           if (link < RLINK_FREE) core_link[link[5:0]] = LINK_FREE;
                           link = RLINK_INVALID;
                        end else begin
                           hit = 1'b1;
                           if (core_link[i] == LINK_FREE) begin
                              core_link[i] = {1'b0, idx[7:0]};
                              link = i[6:0];
                           end else begin
                              core_link[i] = LINK_INVALID;
                              link = RLINK_INVALID;
                           end
                        end
                     end
                  end
               end
            end
         end
         REQ_FINISH: begin
            last_i = -1;
            for (i = 0; i < n_cores; i++)
               if (core_link[i] < LINK_FREE) last_i = i;
            if (last_i < 0) begin
               owed_results.insert(owed_results.size(),
                                   {KIND_NONE, 8'd0, 6'd0, dropped, 1'b1});
            end else begin
               for (i = 0; i <= last_i; i++)
                  if (core_link[i] < LINK_FREE)
                     owed_results.insert(owed_results.size(),
                                         {KIND_PAIR, core_link[i][7:0], i[5:0],
                                          dropped, i == last_i});
            end
            clear_tables();
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input pair_rsp_type want,
                         input pair_rsp_type got);
      errors++;
      if (errors <= 10) begin
         $display("%0t %s: expected kind=%0d ring=%0d core=%0d ovf=%0d last=%0d",
                  $time, what, want.kind, want.ring, want.core, want.overflow, want.last);
         $display("%0t %s: got      kind=%0d ring=%0d core=%0d ovf=%0d last=%0d",
                  $time, what, got.kind, got.ring, got.core, got.overflow, got.last);
      end
   endtask

   task automatic push_item(input logic [1:0] kind, input logic [15:0] col,
                            input logic [15:0] row, input logic [9:0] w,
                            input logic [9:0] h, input logic coding);
      pending_items.insert(pending_items.size(), {kind, col, row, w, h, coding});
      queued++;
   endtask

   // one frame: cores, then rings mostly placed around them, then finish
   task automatic gen_frame(input int n_core, input int n_ring, input int spread,
                            input bit lock_step);
      logic [15:0] fc_col[$];
      logic [15:0] fc_row[$];
      logic [15:0] base_col, base_row, c, r;
      logic [9:0]  w, h;
      int          k, j;
      base_col = 16'($urandom);
      base_row = 16'($urandom);
      for (k = 0; k < n_core; k++) begin
         if (!lock_step && $urandom_range(3) == 0) begin
            c = 16'($urandom);
            r = 16'($urandom);
         end else begin
            c = base_col + 16'($urandom_range(spread));
            r = base_row + 16'($urandom_range(spread));
         end
         fc_col.insert(fc_col.size(), c);
         fc_row.insert(fc_row.size(), r);
         push_item(REQ_LOAD, c, r, 10'($urandom), 10'($urandom), 1'($urandom));
      end
      for (k = 0; k < n_ring; k++) begin
         if (!lock_step) begin
            j = $urandom_range(99);
            if (j < 6) begin
               push_item(REQ_UNUSED, 16'($urandom), 16'($urandom), 10'($urandom),
                         10'($urandom), 1'($urandom));
            end else if (j < 10) begin
               c = 16'($urandom);
               r = 16'($urandom);
               fc_col.insert(fc_col.size(), c);
               fc_row.insert(fc_row.size(), r);
               push_item(REQ_LOAD, c, r, 10'($urandom), 10'($urandom), 1'($urandom));
            end
         end
         if ($urandom_range(9) == 0) begin
            w = 10'($urandom);
            h = 10'($urandom);
         end else begin
            w = 10'($urandom_range(30));
            h = 10'($urandom_range(30));
         end
         if (lock_step) begin
            j = k % fc_col.size();
            c = fc_col[j] + 16'($urandom_range(40)) - 16'd20;
            r = fc_row[j] + 16'($urandom_range(40)) - 16'd20;
            push_item(REQ_RING, c, r, 10'($urandom_range(20, 1023)),
                      10'($urandom_range(20, 1023)), 1'b0);
         end else if (fc_col.size() != 0 && $urandom_range(99) < 75) begin
            j = $urandom_range(fc_col.size() - 1);
            c = fc_col[j] + 16'($urandom_range(180)) - 16'd90;
            r = fc_row[j] + 16'($urandom_range(180)) - 16'd90;
            push_item(REQ_RING, c, r, w, h, $urandom_range(99) < 20);
         end else begin
            push_item(REQ_RING, 16'($urandom), 16'($urandom), w, h,
                      $urandom_range(99) < 20);
         end
      end
      push_item(REQ_FINISH, 16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom),
                1'($urandom));
   endtask

   task automatic wait_sent();
      while (pending_items.size() != 0 || req_valid) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         item_taken = 1'b0;
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
            next_item = pending_items.pop_front();
            {req_type, req_pos_col, req_pos_row, req_ring_width, req_ring_height,
             req_is_coding} <= next_item;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_rsp = {rsp_result_kind, rsp_ring_index, rsp_core_index, rsp_overflow,
                        rsp_last};
            if (owed_results.size() == 0) begin
               report("unexpected result", 'x, seen_rsp);
            end else begin
               want_rsp = owed_results.pop_front();
               if (seen_rsp !== want_rsp) report("result mismatch", want_rsp, seen_rsp);
            end
         end
         if (req_valid && req_ready) begin
            pair_step({req_type, req_pos_col, req_pos_row, req_ring_width, req_ring_height,
                       req_is_coding});
            item_taken = 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("** ring_core_pairing_prune_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      rsp_ready       = 1'b0;
      req_type        = REQ_LOAD;
      req_pos_col     = '0;
      req_pos_row     = '0;
      req_ring_width  = '0;
      req_ring_height = '0;
      req_is_coding   = 1'b0;
      queued          = 0;
      errors          = 0;
      quiet_cycles    = 0;
      item_taken      = 1'b0;
      send_idle       = 22;
      recv_idle       = 80;
      clear_tables();

      // empty finish, coding marker, corner positions, zero size, radius edge,
      // double claim, ignored request
      push_item(REQ_FINISH, 16'd0, 16'd0, 10'd0, 10'd0, 1'b0);
      push_item(REQ_RING, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
      push_item(REQ_LOAD, 16'd0, 16'd0, 10'd0, 10'd0, 1'b0);
      push_item(REQ_LOAD, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
      push_item(REQ_RING, 16'd0, 16'd0, 10'h3FF, 10'h3FF, 1'b0);
      push_item(REQ_RING, 16'hFFFF, 16'hFFFF, 10'd0, 10'd0, 1'b0);
      push_item(REQ_RING, 16'd65456, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b0);
      push_item(REQ_RING, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b0);
      push_item(REQ_RING, 16'hFFFF, 16'd65456, 10'h3FF, 10'h3FF, 1'b0);
      push_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
      push_item(REQ_FINISH, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 1'b1);
      // ring over three cores, exact 5 px miss, small-ring radius edge
      push_item(REQ_LOAD, 16'd1000, 16'd1000, 10'd0, 10'd0, 1'b0);
      push_item(REQ_LOAD, 16'd1040, 16'd1000, 10'd0, 10'd0, 1'b0);
      push_item(REQ_LOAD, 16'd1000, 16'd1040, 10'd0, 10'd0, 1'b0);
      push_item(REQ_LOAD, 16'd5000, 16'd5000, 10'd0, 10'd0, 1'b0);
      push_item(REQ_RING, 16'd1020, 16'd1020, 10'd100, 10'd100, 1'b0);
      push_item(REQ_RING, 16'd1000, 16'd920, 10'd100, 10'd100, 1'b0);
      push_item(REQ_RING, 16'd5023, 16'd5000, 10'd5, 10'd5, 1'b0);
      push_item(REQ_RING, 16'd5024, 16'd5000, 10'd5, 10'd5, 1'b0);
      push_item(REQ_RING, 16'd1040, 16'd1000, 10'd1, 10'd1, 1'b0);
      push_item(REQ_FINISH, 16'd0, 16'd0, 10'd0, 10'd0, 1'b0);

      while (queued < 50)
         gen_frame($urandom_range(8), $urandom_range(12), $urandom_range(20, 400), 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait_sent();

      send_idle = 80;
      recv_idle = 22;
      // full core table plus overflow, one ring per core
      gen_frame(CORES + 2, CORES, 65535, 1'b1);
      while (queued < 190)
         gen_frame($urandom_range(8), $urandom_range(12), $urandom_range(20, 400), 1'b0);
      wait_sent();

      send_idle = 0;
      recv_idle = 0;
      // ring count past capacity
      gen_frame(3, RINGS + 6, 300, 1'b0);
      wait_sent();

      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("** ring_core_pairing_prune_top: PASSED **");
      else
         $display("** ring_core_pairing_prune_top: FAILED **");
      $finish;
   end

endmodule
